>>> hw/rtl/lcdx_pkg.sv
// Shared types, command codes and the microprogram for the character-LCD expander sequencer.
// No dependencies; every other file in hw/rtl imports this package.
package lcdx_pkg;

    localparam int PcW = 5;

    typedef enum logic [2:0] {
        CMD_INIT       = 3'd0,
        CMD_SET_FLAG   = 3'd1,
        CMD_CLEAR      = 3'd2,
        CMD_HOME       = 3'd3,
        CMD_SET_CURSOR = 3'd4,
        CMD_WRITE_CHAR = 3'd5,
        CMD_BACKLIGHT  = 3'd6,
        CMD_NONE       = 3'd7
    } t_cmd;

    localparam logic [1:0] FLAG_SCREEN = 2'd0;
    localparam logic [1:0] FLAG_CURSOR = 2'd1;
    localparam logic [1:0] FLAG_BLINK  = 2'd2;

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_EXP_ADDR  = 1'b1;

    localparam logic [2:0] ROW_COUNT_RST = 3'd2;
    localparam logic [6:0] EXP_ADDR_RST  = 7'd39;

    localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    localparam logic [7:0] LCD_DISP_CTRL = 8'h08;
    localparam logic [7:0] LCD_CLEAR     = 8'h01;
    localparam logic [7:0] LCD_HOME      = 8'h02;
    localparam logic [7:0] LCD_SET_DDRAM = 8'h80;

    localparam logic [PcW-1:0] ENTRY_INIT  = 5'd0;
    localparam logic [PcW-1:0] ENTRY_VALUE = 5'd14;
    localparam logic [PcW-1:0] ENTRY_BL    = 5'd16;

    // one control word per nibble step
    typedef struct packed {
        logic       src_val;   // nibble from value register, else constant
        logic       half_hi;   // high nibble of value register
        logic [3:0] cnib;
        logic       single;    // one beat only, no E strobe
        logic       last;      // end of program
    } t_uword;

    // step handed from sequencer to datapath
    typedef struct packed {
        logic       step;
        logic       src_val;
        logic       half_hi;
        logic [3:0] cnib;
        logic       e_bit;
        logic       last;
    } t_step;

    function automatic t_uword lcdx_urom(input logic [PcW-1:0] pc);
        t_uword w;
        w = '{src_val: 1'b0, half_hi: 1'b0, cnib: 4'h0, single: 1'b0, last: 1'b0};
        case (pc)
            5'd0, 5'd1, 5'd2: w.cnib = 4'h3;
            5'd3:  w.cnib = 4'h2;
            5'd4:  w.cnib = 4'h2;
            5'd5:  w.cnib = 4'h8;
            5'd6:  begin
                w.src_val = 1'b1;
                w.half_hi = 1'b1;
            end
            5'd7:  w.src_val = 1'b1;
            5'd8:  w.cnib = 4'h0;
            5'd9:  w.cnib = 4'h1;
            5'd10: w.cnib = 4'h0;
            5'd11: w.cnib = 4'h6;
            5'd12: w.cnib = 4'h0;
            5'd13: begin
                w.cnib = 4'h2;
                w.last = 1'b1;
            end
            5'd14: begin
                w.src_val = 1'b1;
                w.half_hi = 1'b1;
            end
            5'd15: begin
                w.src_val = 1'b1;
                w.last    = 1'b1;
            end
            5'd16: begin
                w.single = 1'b1;
                w.last   = 1'b1;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/lcdx_cfg.sv
// APB register block: row count and expander bus address.
// Depends on lcdx_pkg for register indexes and reset values.
module lcdx_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [2:0]  o_row_count
);
    import lcdx_pkg::*;

    logic [2:0] r_row_count;
    logic [6:0] r_exp_addr;
    logic       wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RST;
            r_exp_addr  <= EXP_ADDR_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_ROW_COUNT: r_row_count <= pwdata[2:0];
                REG_EXP_ADDR:  r_exp_addr  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROW_COUNT: prdata = {29'd0, r_row_count};
            REG_EXP_ADDR:  prdata = {25'd0, r_exp_addr};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_row_count = r_row_count;
endmodule

>>> hw/rtl/lcdx_seq.sv
// Microprogram sequencer: step counter, E-phase counter and command dispatch.
// Depends on lcdx_pkg for the control-word ROM and step struct.
module lcdx_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [2:0]         i_command,
    input  logic               i_advance,
    output logic               o_busy,
    output lcdx_pkg::t_step    o_step
);
    import lcdx_pkg::*;

    logic           r_busy, n_busy;
    logic [PcW-1:0] r_pc, n_pc;
    logic [1:0]     r_ph, n_ph;
    t_uword         uw;
    logic           nib_done;
    logic           start;
    logic [PcW-1:0] entry;

    assign uw       = lcdx_urom(r_pc);
    assign nib_done = uw.single || (r_ph == 2'd2);

    always_comb begin
        start = 1'b1;
        entry = ENTRY_VALUE;
        case (i_command)
            CMD_INIT:      entry = ENTRY_INIT;
            CMD_SET_FLAG, CMD_CLEAR, CMD_HOME, CMD_SET_CURSOR, CMD_WRITE_CHAR:
                entry = ENTRY_VALUE;
            CMD_BACKLIGHT: entry = ENTRY_BL;
            default:       start = 1'b0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_ph   = r_ph;
        if (i_accept && start) begin
            n_busy = 1'b1;
            n_pc   = entry;
            n_ph   = 2'd0;
        end else if (r_busy && i_advance) begin
            if (nib_done) begin
                n_ph = 2'd0;
                if (uw.last) n_busy = 1'b0;
                else         n_pc   = r_pc + 1'b1;
            end else begin
                n_ph = r_ph + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
            r_ph   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_ph   <= n_ph;
        end
    end

    assign o_busy          = r_busy;
    assign o_step.step     = r_busy && i_advance;
    assign o_step.src_val  = uw.src_val;
    assign o_step.half_hi  = uw.half_hi;
    assign o_step.cnib     = uw.cnib;
    assign o_step.e_bit    = (r_ph == 2'd1) && !uw.single;
    assign o_step.last     = nib_done && uw.last;
endmodule

>>> hw/rtl/lcdx_dp.sv
// Datapath: display flags, backlight, value register, byte assembly and output register.
// Depends on lcdx_pkg for command codes, LCD constants and the step struct.
module lcdx_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [2:0]       i_command,
    input  logic [1:0]       i_flag_select,
    input  logic             i_flag_value,
    input  logic [5:0]       i_cursor_col,
    input  logic [2:0]       i_cursor_row,
    input  logic [7:0]       i_char_code,
    input  logic [2:0]       i_row_count,
    input  lcdx_pkg::t_step  i_step,
    input  logic             i_out_ready,
    output logic             o_advance,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);
    import lcdx_pkg::*;

    logic [2:0] r_flags, n_flags;
    logic       r_bl, n_bl;
    logic [7:0] r_val, n_val;
    logic       r_rs;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic [2:0] sel_bit;
    logic [2:0] rows;
    logic [1:0] row_eff;
    logic [7:0] cursor_addr;
    logic [3:0] nib;

    always_comb begin
        case (i_flag_select)
            FLAG_SCREEN: sel_bit = 3'b100;
            FLAG_CURSOR: sel_bit = 3'b010;
            FLAG_BLINK:  sel_bit = 3'b001;
            default:     sel_bit = 3'b000;
        endcase
        case (i_row_count)
            3'd0:                rows = 3'd1;
            3'd1, 3'd2, 3'd3, 3'd4: rows = i_row_count;
            default:             rows = 3'd4;
        endcase
        if (i_cursor_row >= rows) row_eff = 2'(rows - 3'd1);
        else                      row_eff = i_cursor_row[1:0];
        cursor_addr = LCD_SET_DDRAM | (8'(i_cursor_col) + ROW_BASE[row_eff]);
    end

    always_comb begin
        n_flags = r_flags;
        n_bl    = r_bl;
        n_val   = r_val;
        if (i_accept) begin
            case (i_command)
                CMD_INIT: begin
                    n_flags = r_flags | 3'b100;
                    n_val   = LCD_DISP_CTRL | {5'd0, n_flags};
                end
                CMD_SET_FLAG: begin
                    n_flags = i_flag_value ? (r_flags | sel_bit) : (r_flags & ~sel_bit);
                    n_val   = LCD_DISP_CTRL | {5'd0, n_flags};
                end
                CMD_CLEAR:      n_val = LCD_CLEAR;
                CMD_HOME:       n_val = LCD_HOME;
                CMD_SET_CURSOR: n_val = cursor_addr;
                CMD_WRITE_CHAR: n_val = i_char_code;
                CMD_BACKLIGHT:  n_bl  = i_flag_value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_bl    <= 1'b0;
        end else begin
            r_flags <= n_flags;
            r_bl    <= n_bl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (i_accept) r_rs <= (i_command == CMD_WRITE_CHAR);
    end

    assign o_advance = !r_out_valid || i_out_ready;

    always_comb begin
        if (!i_step.src_val) nib = i_step.cnib;
        else if (i_step.half_hi) nib = r_val[7:4];
        else nib = r_val[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_step.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.step) begin
            r_out_byte <= {nib, r_bl, i_step.e_bit, 1'b0, r_rs};
            r_out_last <= i_step.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
endmodule

>>> hw/rtl/char_lcd_expander_sequencer_top.sv
// Top level of the character-LCD expander sequencer: APB registers, sequencer, datapath.
// Depends on lcdx_pkg, lcdx_cfg, lcdx_seq and lcdx_dp.
//
// channel   signals                                   direction
// in        i_in_valid / o_in_ready + command fields  LCD operation, one per beat
// out       o_out_valid / i_out_ready + byte, last    expander byte, one per beat
// cfg       psel penable pwrite paddr pwdata prdata   row_count @0, expander_address @4
//
// An operation emits 6 expander bytes (set flag, clear, home, set cursor, write char), 42 for
// init or 1 for backlight, and the input stays not ready from its accept until its last byte
// is registered; unknown command 7 is dropped in the accept cycle. Unless the output stalls,
// one expander byte leaves per cycle, paced by the sequencer's nibble ROM and E-phase counter.
// The next operation is taken the cycle after the previous one's last byte is registered.
// Output stalls freeze the sequencer; synchronous active-low reset clears flags and backlight.
module char_lcd_expander_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [1:0]  i_flag_select,
    input  logic        i_flag_value,
    input  logic [5:0]  i_cursor_col,
    input  logic [2:0]  i_cursor_row,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_expander_byte,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcdx_pkg::*;

    logic       busy;
    logic       accept;
    logic       advance;
    logic [2:0] row_count;
    t_step      step;

    assign o_in_ready = !busy;
    assign accept     = i_in_valid && !busy;

    lcdx_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_row_count (row_count)
    );

    lcdx_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_command (i_command),
        .i_advance (advance),
        .o_busy    (busy),
        .o_step    (step)
    );

    lcdx_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_command     (i_command),
        .i_flag_select (i_flag_select),
        .i_flag_value  (i_flag_value),
        .i_cursor_col  (i_cursor_col),
        .i_cursor_row  (i_cursor_row),
        .i_char_code   (i_char_code),
        .i_row_count   (row_count),
        .i_step        (step),
        .i_out_ready   (i_out_ready),
        .o_advance     (advance),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_expander_byte),
        .o_out_last    (o_last)
    );
endmodule

>>> hw/rtl/lcdx_chk.sv
// Port-level checker for the character-LCD expander sequencer, bound to the top level.
// Depends on lcdx_pkg for command codes.
module lcdx_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [2:0] i_command,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_expander_byte,
    input logic       o_last
);
    import lcdx_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_expander_byte) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_strobe_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_expander_byte[2] |-> !o_last)
        else $error("beat with E high marked last");

    a_bit1_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_expander_byte[1])
        else $error("expander bit 1 set");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command != CMD_NONE) |=> !o_in_ready)
        else $error("input ready right after a command was taken");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
endmodule

bind char_lcd_expander_sequencer_top lcdx_chk u_lcdx_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_command       (i_command),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_expander_byte (o_expander_byte),
    .o_last          (o_last)
);

>>> verif/char_lcd_expander_sequencer_top_tb.sv
`timescale 1ns / 100ps
// Testbench for char_lcd_expander_sequencer_top: drives LCD operations and APB register writes,
// predicts every expander byte and checks each output beat in order. Depends on lcdx_pkg.

import lcdx_pkg::*;

localparam logic [2:0] CMD_UNKNOWN    = 3'd7;
localparam logic [1:0] FLAG_NONE      = 2'd3;
localparam logic [2:0] DF_SCREEN      = 3'b100;
localparam logic [2:0] DF_CURSOR      = 3'b010;
localparam logic [2:0] DF_BLINK       = 3'b001;
localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
localparam logic [3:0] INIT_NIB_WAKE  = 4'h3;
localparam logic [3:0] INIT_NIB_4BIT  = 4'h2;
localparam logic [7:0] EXP_BL         = 8'h08;
localparam logic [7:0] EXP_E          = 8'h04;
localparam logic [7:0] EXP_RS         = 8'h01;

typedef struct packed {
    logic [7:0] lcd_byte;
    logic       tail;
} expander_beat_t;

class lcd_expander_scoreboard;
    logic [2:0]     rows_cfg  = ROW_COUNT_RST;
    logic [2:0]     disp_flags = '0;
    logic           bl_on     = 1'b0;
    expander_beat_t beats[$];
    int             faults    = 0;

    function void push_nibble(logic [3:0] nib, logic rs);
        logic [7:0] p;
        p = {nib, 4'h0};
        if (bl_on) p = p | EXP_BL;
        if (rs) p = p | EXP_RS;
        beats.push_back('{lcd_byte: p, tail: 1'b0});
        beats.push_back('{lcd_byte: p | EXP_E, tail: 1'b0});
        beats.push_back('{lcd_byte: p, tail: 1'b0});
    endfunction

    function void push_value(logic [7:0] v, logic rs);
        push_nibble(v[7:4], rs);
        push_nibble(v[3:0], rs);
    endfunction

    function void note_op(logic [2:0] cmd, logic [1:0] sel, logic val, logic [5:0] col,
                          logic [2:0] row, logic [7:0] ch);
        int         base;
        logic [2:0] eff;
        logic [2:0] r;
        logic [2:0] m;
        logic [7:0] ddram;
        base = beats.size();
        case (cmd)
            CMD_INIT: begin
                push_nibble(INIT_NIB_WAKE, 1'b0);
                push_nibble(INIT_NIB_WAKE, 1'b0);
                push_nibble(INIT_NIB_WAKE, 1'b0);
                push_nibble(INIT_NIB_4BIT, 1'b0);
                push_value(LCD_FUNC_SET, 1'b0);
                disp_flags = disp_flags | DF_SCREEN;
                push_value(LCD_DISP_CTRL | {5'b0, disp_flags}, 1'b0);
                push_value(LCD_CLEAR, 1'b0);
                push_value(LCD_ENTRY_MODE, 1'b0);
                push_value(LCD_HOME, 1'b0);
            end
            CMD_SET_FLAG: begin
                case (sel)
                    FLAG_SCREEN: m = DF_SCREEN;
                    FLAG_CURSOR: m = DF_CURSOR;
                    FLAG_BLINK:  m = DF_BLINK;
                    default:     m = '0;
                endcase
                disp_flags = val ? (disp_flags | m) : (disp_flags & ~m);
                push_value(LCD_DISP_CTRL | {5'b0, disp_flags}, 1'b0);
            end
            CMD_CLEAR: push_value(LCD_CLEAR, 1'b0);
            CMD_HOME:  push_value(LCD_HOME, 1'b0);
            CMD_SET_CURSOR: begin
                eff = (rows_cfg == 3'd0) ? 3'd1 : ((rows_cfg > 3'd4) ? 3'd4 : rows_cfg);
                r = (row >= eff) ? eff - 3'd1 : row;
                ddram = {2'b00, col} + ROW_BASE[r[1:0]];
                push_value(LCD_SET_DDRAM | ddram, 1'b0);
            end
            CMD_WRITE_CHAR: push_value(ch, 1'b1);
            CMD_BACKLIGHT: begin
                bl_on = val;
                beats.push_back('{lcd_byte: (val ? EXP_BL : 8'h00), tail: 1'b0});
            end
            default: ;
        endcase
        if (beats.size() > base) beats[beats.size() - 1].tail = 1'b1;
    endfunction

    function void check_beat(logic [7:0] got_byte, logic got_tail);
        expander_beat_t want;
        if (beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual byte %h last %b",
                     $time, got_byte, got_tail);
            faults++;
        end else begin
            want = beats.pop_front();
            if (got_byte !== want.lcd_byte) begin
                $display("%0t: expander_byte mismatch, expected %h, actual %h",
                         $time, want.lcd_byte, got_byte);
                faults++;
            end
            if (got_tail !== want.tail) begin
                $display("%0t: last mismatch, expected %b, actual %b",
                         $time, want.tail, got_tail);
                faults++;
            end
        end
    endfunction

    function int pending();
        return beats.size();
    endfunction
endclass

module char_lcd_expander_sequencer_top_tb;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_command       = '0;
    logic [1:0]  i_flag_select   = '0;
    logic        i_flag_value    = 1'b0;
    logic [5:0]  i_cursor_col    = '0;
    logic [2:0]  i_cursor_row    = '0;
    logic [7:0]  i_char_code     = '0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [7:0]  o_expander_byte;
    logic        o_last;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [2:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic [31:0] prdata;
    logic        pready;

    lcd_expander_scoreboard sb = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold      = 0;

    logic [2:0] row_plan [8] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd6};

    char_lcd_expander_sequencer_top i_dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_beat(o_expander_byte, o_last);
    end

    task automatic send_op(input logic [2:0] cmd, input logic [1:0] sel, input logic val,
                           input logic [5:0] col, input logic [2:0] row,
                           input logic [7:0] ch);
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_flag_select <= sel;
        i_flag_value  <= val;
        i_cursor_col  <= col;
        i_cursor_row  <= row;
        i_char_code   <= ch;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_op(cmd, sel, val, col, row, ch);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] value, input logic [31:0] mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_ROW_COUNT) sb.rows_cfg = value[2:0];
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== (value & mask)) begin
            $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                     $time, idx, value & mask, prdata & mask);
            sb.faults++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int         pick;
        logic [2:0] cmd;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(CMD_BACKLIGHT, 2'd3, 1'b1, 6'd39, 3'd7, 8'hFF);
        send_op(CMD_INIT, 2'd0, 1'b0, 6'd0, 3'd0, 8'h00);
        send_op(CMD_SET_FLAG, FLAG_CURSOR, 1'b1, 6'd0, 3'd0, 8'h00);
        send_op(CMD_SET_FLAG, FLAG_BLINK, 1'b1, 6'd0, 3'd0, 8'h00);
        send_op(CMD_SET_FLAG, FLAG_BLINK, 1'b0, 6'd0, 3'd0, 8'h00);
        send_op(CMD_SET_FLAG, FLAG_SCREEN, 1'b0, 6'd0, 3'd0, 8'h00);
        send_op(CMD_SET_FLAG, FLAG_NONE, 1'b1, 6'd39, 3'd7, 8'hFF);
        send_op(CMD_SET_FLAG, FLAG_SCREEN, 1'b1, 6'd0, 3'd0, 8'h00);
        send_op(CMD_CLEAR, 2'd0, 1'b0, 6'd0, 3'd0, 8'h00);
        send_op(CMD_HOME, 2'd3, 1'b1, 6'd39, 3'd7, 8'hFF);
        send_op(CMD_SET_CURSOR, 2'd0, 1'b0, 6'd0, 3'd0, 8'h00);
        send_op(CMD_SET_CURSOR, 2'd0, 1'b0, 6'd39, 3'd1, 8'h00);
        send_op(CMD_SET_CURSOR, 2'd0, 1'b0, 6'd39, 3'd7, 8'h00);
        send_op(CMD_SET_CURSOR, 2'd0, 1'b0, 6'd21, 3'd2, 8'h00);
        send_op(CMD_SET_CURSOR, 2'd3, 1'b1, 6'd0, 3'd3, 8'hFF);
        send_op(CMD_WRITE_CHAR, 2'd0, 1'b0, 6'd0, 3'd0, 8'h00);
        send_op(CMD_WRITE_CHAR, 2'd0, 1'b0, 6'd0, 3'd0, 8'hFF);
        send_op(CMD_WRITE_CHAR, 2'd0, 1'b0, 6'd0, 3'd0, 8'hA5);
        send_op(CMD_UNKNOWN, 2'd3, 1'b1, 6'd39, 3'd7, 8'hFF);
        send_op(CMD_BACKLIGHT, 2'd0, 1'b0, 6'd0, 3'd0, 8'h00);
        send_op(CMD_WRITE_CHAR, 2'd0, 1'b0, 6'd0, 3'd0, 8'h5A);
        send_op(CMD_INIT, 2'd3, 1'b1, 6'd39, 3'd7, 8'hFF);

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            cfg_write(REG_ROW_COUNT, {29'd0, row_plan[p]}, 32'h7);
            cfg_write(REG_EXP_ADDR,
                      (p == 0) ? 32'd0 : ((p == 1) ? 32'd127 : $urandom_range(127)),
                      32'h7F);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
                default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
            endcase
            if (p == 0) rx_hold = 300;
            for (int n = 0; n < 60; n++) begin
                pick = $urandom_range(99);
                if (pick < 5)       cmd = CMD_INIT;
                else if (pick < 25) cmd = CMD_SET_FLAG;
                else if (pick < 33) cmd = CMD_CLEAR;
                else if (pick < 41) cmd = CMD_HOME;
                else if (pick < 61) cmd = CMD_SET_CURSOR;
                else if (pick < 89) cmd = CMD_WRITE_CHAR;
                else if (pick < 96) cmd = CMD_BACKLIGHT;
                else                cmd = CMD_UNKNOWN;
                send_op(cmd, 2'($urandom_range(3)), 1'($urandom_range(1)),
                        6'($urandom_range(39)), 3'($urandom_range(7)),
                        8'($urandom_range(255)));
            end
        end

        wait_drained();
        if (sb.faults == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> char_lcd_expander_sequencer_top.f
hw/rtl/lcdx_pkg.sv
hw/rtl/lcdx_cfg.sv
hw/rtl/lcdx_seq.sv
hw/rtl/lcdx_dp.sv
hw/rtl/char_lcd_expander_sequencer_top.sv
hw/rtl/lcdx_chk.sv
verif/char_lcd_expander_sequencer_top_tb.sv
